FILE: rtl/mbss_pkg.sv
// types, codes and defaults shared by the substring search block
`timescale 1ns / 1ps

package mbss_pkg;

    localparam int TEXT_DEPTH_DEF    = 1024;
    localparam int PATTERN_DEPTH_DEF = 64;
    localparam int QUEUE_DEPTH       = 4;
    localparam int POS_W             = 10;
    localparam int MAP_DEPTH         = 256;

    localparam logic [1:0] MODE_LEAD    = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_TEXT    = 2'd2;
    localparam logic [1:0] MODE_SEARCH  = 2'd3;

    localparam logic [2:0] STATUS_FOUND       = 3'd0;
    localparam logic [2:0] STATUS_NOT_FOUND   = 3'd1;
    localparam logic [2:0] STATUS_EMPTY_TEXT  = 3'd2;
    localparam logic [2:0] STATUS_BAD_PATTERN = 3'd3;
    localparam logic [2:0] STATUS_OVERRUN     = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] byte_value;
        logic       lead_flag;
    } cmd_beat_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] position;
    } rsp_beat_t;

    typedef enum logic [1:0] {
        OP_LEAD,
        OP_PATTERN,
        OP_TEXT,
        OP_SEARCH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       flag;
    } op_beat_t;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_READ,
        BS_LOOKUP,
        BS_COMPARE,
        BS_DONE
    } back_state_t;

endpackage

FILE: rtl/mbss_front.sv
// front stage: takes command beats and classifies them into operations
`timescale 1ns / 1ps

module mbss_front
    import mbss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      op_valid,
    input  logic      op_stall,
    output op_beat_t  op
);

    logic     hold_valid_reg;
    logic     hold_valid_next;
    op_beat_t hold_reg;
    op_beat_t decoded;
    logic     take;

    always_comb
    begin
        decoded.data = cmd.byte_value;
        decoded.flag = cmd.lead_flag;
        case (cmd.mode)
            MODE_LEAD:    decoded.op = OP_LEAD;
            MODE_PATTERN: decoded.op = OP_PATTERN;
            MODE_TEXT:    decoded.op = OP_TEXT;
            MODE_SEARCH:  decoded.op = OP_SEARCH;
            default:      decoded.op = OP_SEARCH;
        endcase
    end

    assign cmd_stall = hold_valid_reg && op_stall;
    assign take      = cmd_valid && !cmd_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (!hold_valid_reg || !op_stall)
        begin
            hold_valid_next = cmd_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= decoded;
        end
    end

    assign op_valid = hold_valid_reg;
    assign op       = hold_reg;

endmodule

FILE: rtl/mbss_queue.sv
// short queue of classified operations between front and back
`timescale 1ns / 1ps

module mbss_queue
    import mbss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_stall,
    input  op_beat_t push_data,
    output logic     pop_valid,
    input  logic     pop,
    output op_beat_t pop_data
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    op_beat_t       slot_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] fill_reg;
    logic [QCW-1:0] fill_next;
    logic           do_push;
    logic           do_pop;

    assign push_stall = (fill_reg == QCW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/mbss_back.sv
// back end: stores, lead map, search sequencer and result register
`timescale 1ns / 1ps

module mbss_back
    import mbss_pkg::*;
#(
    parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  op_beat_t  q_op,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    localparam int TAW = $clog2(TEXT_DEPTH);
    localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
    localparam int TCW = $clog2(TEXT_DEPTH + 1);
    localparam int PCW = $clog2(PATTERN_DEPTH + 1);
    localparam int SW  = ((TCW > PCW) ? TCW : PCW) + 2;
    localparam int MAW = $clog2(MAP_DEPTH);

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [TCW-1:0]   tc_reg;
    logic [TCW-1:0]   tc_next;
    logic [PCW-1:0]   pc_reg;
    logic [PCW-1:0]   pc_next;
    logic             ovr_reg;
    logic             ovr_next;
    logic [TCW-1:0]   i_reg;
    logic [TCW-1:0]   i_next;
    logic [PCW-1:0]   k_reg;
    logic [PCW-1:0]   k_next;
    logic             lead_reg;
    logic             lead_next;
    logic [2:0]       status_reg;
    logic [2:0]       status_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_beat_t        rsp_reg;
    rsp_beat_t        rsp_next;
    logic [MAW-1:0]   clr_reg;
    logic [MAW-1:0]   clr_next;

    logic             lead_mem [MAP_DEPTH];
    logic [7:0]       text_mem [TEXT_DEPTH];
    logic [7:0]       pat_mem [PATTERN_DEPTH];
    logic [7:0]       text_rd_reg;
    logic [7:0]       pat_rd_reg;
    logic             lead_rd_reg;

    logic             map_we;
    logic [MAW-1:0]   map_addr;
    logic             map_data;
    logic             text_we;
    logic             pat_we;
    logic [SW-1:0]    tc_ext;
    logic [SW-1:0]    pc_ext;
    logic [SW-1:0]    t_sum;
    logic [SW-1:0]    i_step;
    logic [TAW-1:0]   t_addr;
    logic [PAW-1:0]   p_addr;
    logic             lead_cur;
    logic             eq;
    logic             last_k;
    logic             tail_fail;
    logic             search_err;
    logic             rsp_free;
    logic [TCW+POS_W-1:0] pos_ext;

    assign tc_ext     = SW'(tc_reg);
    assign pc_ext     = SW'(pc_reg);
    assign t_sum      = SW'(i_reg) + SW'(k_reg);
    assign t_addr     = t_sum[TAW-1:0];
    assign p_addr     = k_reg[PAW-1:0];
    assign lead_cur   = (k_reg == '0) ? lead_rd_reg : lead_reg;
    assign eq         = (text_rd_reg == pat_rd_reg);
    assign last_k     = (PCW'(k_reg + 1'b1) == pc_reg);
    assign i_step     = SW'(i_reg) + SW'(1) + SW'(lead_cur);
    assign tail_fail  = (i_step + pc_ext) > tc_ext;
    assign search_err = ovr_reg || (tc_reg == '0) || (pc_reg == '0) || (pc_ext > tc_ext);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign pos_ext    = {{POS_W{1'b0}}, i_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_CLEAR:
            begin
                if (clr_reg == MAW'(MAP_DEPTH - 1))
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (q_valid && q_op.op == OP_SEARCH)
                begin
                    state_next = search_err ? BS_DONE : BS_READ;
                end
            end
            BS_READ:
            begin
                state_next = (k_reg == '0) ? BS_LOOKUP : BS_COMPARE;
            end
            BS_LOOKUP:
            begin
                state_next = BS_COMPARE;
            end
            BS_COMPARE:
            begin
                if (!eq)
                begin
                    state_next = tail_fail ? BS_DONE : BS_READ;
                end
                else
                begin
                    state_next = last_k ? BS_DONE : BS_READ;
                end
            end
            BS_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        tc_next        = tc_reg;
        pc_next        = pc_reg;
        ovr_next       = ovr_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        lead_next      = lead_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        clr_next       = clr_reg;
        q_pop          = 1'b0;
        map_we         = 1'b0;
        map_addr       = q_op.data;
        map_data       = q_op.flag;
        text_we        = 1'b0;
        pat_we         = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            BS_CLEAR:
            begin
                map_we   = 1'b1;
                map_addr = clr_reg;
                map_data = 1'b0;
                clr_next = clr_reg + 1'b1;
            end
            BS_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_op.op)
                        OP_LEAD:
                        begin
                            map_we = 1'b1;
                        end
                        OP_PATTERN:
                        begin
                            if (pc_reg < PCW'(PATTERN_DEPTH))
                            begin
                                pat_we  = 1'b1;
                                pc_next = pc_reg + 1'b1;
                            end
                            else
                            begin
                                ovr_next = 1'b1;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (tc_reg < TCW'(TEXT_DEPTH))
                            begin
                                text_we = 1'b1;
                                tc_next = tc_reg + 1'b1;
                            end
                            else
                            begin
                                ovr_next = 1'b1;
                            end
                        end
                        OP_SEARCH:
                        begin
                            i_next   = '0;
                            k_next   = '0;
                            pos_next = '0;
                            if (ovr_reg)
                            begin
                                status_next = STATUS_OVERRUN;
                            end
                            else if (tc_reg == '0)
                            begin
                                status_next = STATUS_EMPTY_TEXT;
                            end
                            else
                            begin
                                status_next = STATUS_BAD_PATTERN;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BS_READ:
            begin
                q_pop = 1'b0;
            end
            BS_LOOKUP:
            begin
                q_pop = 1'b0;
            end
            BS_COMPARE:
            begin
                if (k_reg == '0)
                begin
                    lead_next = lead_cur;
                end
                if (eq)
                begin
                    if (last_k)
                    begin
                        status_next = STATUS_FOUND;
                        pos_next    = pos_ext[POS_W-1:0];
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = '0;
                    if (tail_fail)
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        i_next = i_step[TCW-1:0];
                    end
                end
            end
            BS_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.status   = status_reg;
                    rsp_next.position = pos_reg;
                    tc_next           = '0;
                    pc_next           = '0;
                    ovr_next          = 1'b0;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_CLEAR;
            tc_reg        <= '0;
            pc_reg        <= '0;
            ovr_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            clr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            tc_reg        <= tc_next;
            pc_reg        <= pc_next;
            ovr_reg       <= ovr_next;
            rsp_valid_reg <= rsp_valid_next;
            clr_reg       <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        k_reg      <= k_next;
        lead_reg   <= lead_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        rsp_reg    <= rsp_next;
    end

    // lead map, looked up with the text byte just read
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            lead_mem[map_addr] <= map_data;
        end
        lead_rd_reg <= lead_mem[text_rd_reg];
    end

    // text and pattern stores
    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[tc_reg[TAW-1:0]] <= q_op.data;
        end
        text_rd_reg <= text_mem[t_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pc_reg[PAW-1:0]] <= q_op.data;
        end
        pat_rd_reg <= pat_mem[p_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (tc_reg <= TCW'(TEXT_DEPTH)) && (pc_reg <= PCW'(PATTERN_DEPTH)))
        else $error("store count beyond depth");

    a_window_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_READ || state_reg == BS_LOOKUP || state_reg == BS_COMPARE) |->
        ((SW'(i_reg) + pc_ext <= tc_ext) && (k_reg < pc_reg)))
        else $error("compare window leaves the text");

    a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BS_DONE && rsp_free) |=>
        (tc_reg == '0 && pc_reg == '0 && !ovr_reg && rsp_valid_reg))
        else $error("counts not cleared after search");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == BS_DONE))
        else $error("result beat without a finished search");

endmodule

FILE: rtl/multibyte_aware_substring_search.sv
// top level of the multibyte aware substring search block
`timescale 1ns / 1ps

// Command beats load a 256-entry lead-byte map, a pattern store and a text
// store, and a search beat returns one result beat: the first offset where the
// pattern occurs, where an offset after a lead byte of a two-byte character is
// skipped, or an error status. Every search clears the pattern and text counts
// and the overrun flag; the lead map is kept. After reset the back end clears
// the lead map to all single byte; the front stage and the four-entry queue
// hold up to five beats meanwhile, then command beats stall. Load beats retire
// one per cycle while the back end is idle. A search tries offsets in order:
// the first compare at an offset goes through store read, lead map read and
// compare, and each further compare through store read and compare. While a
// search runs or its result waits for the result side, command beats back up
// behind it once the queue fills.

module multibyte_aware_substring_search
    import mbss_pkg::*;
#(
    parameter int TEXT_DEPTH    = TEXT_DEPTH_DEF,
    parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    logic     fe_valid;
    logic     fe_stall;
    op_beat_t fe_op;
    logic     q_valid;
    logic     q_pop;
    op_beat_t q_op;

    mbss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .op_valid  (fe_valid),
        .op_stall  (fe_stall),
        .op        (fe_op)
    );

    mbss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_stall (fe_stall),
        .push_data  (fe_op),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_data   (q_op)
    );

    mbss_back #(
        .TEXT_DEPTH    (TEXT_DEPTH),
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_op      (q_op),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

FILE: sim/multibyte_aware_substring_search_test.sv
// self-checking testbench for the multibyte aware substring search block
`timescale 1ns / 1ps

module multibyte_aware_substring_search_test;
    import mbss_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TOTAL_ITEMS    = 1650;
    localparam int TAIL_ITEMS     = TEXT_DEPTH_DEF + 40;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TAIL_CYCLES    = 50;
    localparam int MAX_REPORTS    = 10;
    localparam int PLAN_LEN       = 25;

    typedef struct packed {
        cmd_beat_t beat;
        logic      typed;
        rsp_beat_t want;
    } plan_row_t;

    localparam rsp_beat_t NO_CHECK = '{STATUS_FOUND, 10'd0};

    // directed rows: typed results where the answer is plain
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{'{MODE_SEARCH, 8'h00, 1'b0}, 1'b1, '{STATUS_EMPTY_TEXT, 10'd0}},
        '{'{MODE_TEXT, 8'h00, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_TEXT, 8'hff, 1'b1}, 1'b0, NO_CHECK},
        '{'{MODE_SEARCH, 8'hff, 1'b1}, 1'b1, '{STATUS_BAD_PATTERN, 10'd0}},
        '{'{MODE_PATTERN, 8'hff, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_SEARCH, 8'h00, 1'b0}, 1'b1, '{STATUS_EMPTY_TEXT, 10'd0}},
        '{'{MODE_LEAD, 8'h81, 1'b1}, 1'b0, NO_CHECK},
        '{'{MODE_TEXT, 8'h81, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_TEXT, 8'h41, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_TEXT, 8'h41, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_PATTERN, 8'h41, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_SEARCH, 8'h00, 1'b0}, 1'b1, '{STATUS_FOUND, 10'd2}},
        '{'{MODE_TEXT, 8'h55, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_PATTERN, 8'haa, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_PATTERN, 8'h55, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_SEARCH, 8'h00, 1'b0}, 1'b1, '{STATUS_BAD_PATTERN, 10'd0}},
        '{'{MODE_TEXT, 8'h12, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_TEXT, 8'h34, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_PATTERN, 8'h34, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_PATTERN, 8'h56, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_SEARCH, 8'h00, 1'b0}, 1'b1, '{STATUS_NOT_FOUND, 10'd0}},
        '{'{MODE_LEAD, 8'h81, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_TEXT, 8'h81, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_PATTERN, 8'h81, 1'b0}, 1'b0, NO_CHECK},
        '{'{MODE_SEARCH, 8'h00, 1'b0}, 1'b0, NO_CHECK}
    };

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_beat_t cmd = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_beat_t rsp;

    // predictor state
    logic       lead_bytes [MAP_DEPTH];
    logic [7:0] text_bytes [TEXT_DEPTH_DEF];
    logic [7:0] pattern_bytes [PATTERN_DEPTH_DEF];
    int         text_len = 0;
    int         pattern_len = 0;
    logic       overrun_seen = 1'b0;

    rsp_beat_t  pending_results [$];
    logic [7:0] alphabet [3];
    bit         no_idle = 1'b0;
    int         beats_sent = 0;
    int         error_count = 0;
    int         idle_cycles = 0;

    multibyte_aware_substring_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic cmd_beat_t beat_of(logic [1:0] mode, logic [7:0] value, logic flag);
        cmd_beat_t b;
        b.mode       = mode;
        b.byte_value = value;
        b.lead_flag  = flag;
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        return alphabet[$urandom_range(0, 2)];
    endfunction

    function automatic rsp_beat_t predict_search();
        rsp_beat_t r;
        int        i;
        bit        hit;
        r.status   = STATUS_NOT_FOUND;
        r.position = '0;
        if (overrun_seen)
            r.status = STATUS_OVERRUN;
        else if (text_len == 0)
            r.status = STATUS_EMPTY_TEXT;
        else if (pattern_len == 0 || pattern_len > text_len)
            r.status = STATUS_BAD_PATTERN;
        else
        begin
            i = 0;
            while (i < text_len && r.status != STATUS_FOUND)
            begin
                hit = (i + pattern_len <= text_len);
                for (int k = 0; k < pattern_len && hit; k++)
                    if (text_bytes[i + k] != pattern_bytes[k])
                        hit = 1'b0;
                if (hit)
                begin
                    r.status   = STATUS_FOUND;
                    r.position = POS_W'(i);
                end
                else
                    i += lead_bytes[text_bytes[i]] ? 2 : 1;
            end
        end
        return r;
    endfunction

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_result(input rsp_beat_t got);
        rsp_beat_t want;
        if (pending_results.size() == 0)
        begin
            note_error($sformatf("unexpected result beat status %0d position %0d",
                                 got.status, got.position));
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            note_error($sformatf("status expected %0d got %0d", want.status, got.status));
        if (got.position !== want.position)
            note_error($sformatf("position expected %0d got %0d",
                                 want.position, got.position));
    endtask

    task automatic send_beat(input cmd_beat_t b, input bit typed = 1'b0,
                             input rsp_beat_t want = '0);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= b;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        beats_sent++;
        case (b.mode)
            MODE_LEAD:
                lead_bytes[b.byte_value] = b.lead_flag;
            MODE_PATTERN:
                if (pattern_len < PATTERN_DEPTH_DEF)
                begin
                    pattern_bytes[pattern_len] = b.byte_value;
                    pattern_len++;
                end
                else
                    overrun_seen = 1'b1;
            MODE_TEXT:
                if (text_len < TEXT_DEPTH_DEF)
                begin
                    text_bytes[text_len] = b.byte_value;
                    text_len++;
                end
                else
                    overrun_seen = 1'b1;
            default:
            begin
                pending_results.push_back(typed ? want : predict_search());
                text_len     = 0;
                pattern_len  = 0;
                overrun_seen = 1'b0;
            end
        endcase
    endtask

    // hold off the sender until every result beat is back
    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic search_now();
        send_beat(beat_of(MODE_SEARCH, 8'($urandom), 1'($urandom)));
    endtask

    task automatic normal_sequence();
        logic [7:0] pat [$];
        logic [7:0] txt [$];
        int         plen;
        int         tlen;
        int         off;
        int         pi;
        int         ti;
        for (int k = 0; k < 3; k++)
            alphabet[k] = 8'($urandom);
        repeat ($urandom_range(0, 2))
            send_beat(beat_of(MODE_LEAD, pick_byte(), 1'($urandom)));
        plen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen) : $urandom_range(plen, 40);
        for (int k = 0; k < plen; k++)
            pat.push_back(pick_byte());
        for (int k = 0; k < tlen; k++)
            txt.push_back(pick_byte());
        if (plen != 0 && tlen >= plen && $urandom_range(0, 1) == 1)
        begin
            off = $urandom_range(0, tlen - plen);
            for (int k = 0; k < plen; k++)
                txt[off + k] = pat[k];
        end
        pi = 0;
        ti = 0;
        while (pi < plen || ti < tlen)
        begin
            if (ti == tlen || (pi < plen && $urandom_range(0, 1) == 0))
            begin
                send_beat(beat_of(MODE_PATTERN, pat[pi], 1'($urandom)));
                pi++;
            end
            else
            begin
                send_beat(beat_of(MODE_TEXT, txt[ti], 1'($urandom)));
                ti++;
            end
        end
        search_now();
    endtask

    task automatic noise_sequence();
        repeat ($urandom_range(4, 12))
            send_beat(beat_of(2'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    // pattern store filled to the brim or past it
    task automatic pattern_fill_sequence();
        repeat ($urandom_range(PATTERN_DEPTH_DEF, PATTERN_DEPTH_DEF + 2))
            send_beat(beat_of(MODE_PATTERN, 8'($urandom), 1'($urandom)));
        repeat ($urandom_range(0, PATTERN_DEPTH_DEF + 6))
            send_beat(beat_of(MODE_TEXT, 8'($urandom), 1'($urandom)));
        search_now();
    endtask

    task automatic full_text_sequence();
        logic [7:0] txt [$];
        for (int j = 0; j < TEXT_DEPTH_DEF; j++)
        begin
            txt.push_back(8'($urandom));
            send_beat(beat_of(MODE_TEXT, txt[j], 1'($urandom)));
        end
        // keep the offset before the tail match from skipping it
        send_beat(beat_of(MODE_LEAD, txt[TEXT_DEPTH_DEF - 4], 1'b0));
        for (int k = TEXT_DEPTH_DEF - 3; k < TEXT_DEPTH_DEF; k++)
            send_beat(beat_of(MODE_PATTERN, txt[k], 1'($urandom)));
        search_now();
    endtask

    // result side with random stalls
    initial
    begin
        int wait_left;
        wait_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                check_result(rsp);
                wait_left = no_idle ? 0 : $urandom_range(0, 3);
                rsp_stall <= (wait_left != 0);
            end
            else if (rsp_valid && wait_left != 0)
            begin
                wait_left--;
                rsp_stall <= (wait_left != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int seq_count;
        int kind;
        for (int k = 0; k < MAP_DEPTH; k++)
            lead_bytes[k] = 1'b0;
        seq_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < PLAN_LEN; n++)
            send_beat(PLAN[n].beat, PLAN[n].typed, PLAN[n].want);
        drain_results();

        while (beats_sent < TOTAL_ITEMS - TAIL_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 8)
                noise_sequence();
            else if (kind < 12)
                pattern_fill_sequence();
            else
                normal_sequence();
            seq_count++;
            if (seq_count % 20 == 0)
                drain_results();
        end

        no_idle = 1'b0;
        full_text_sequence();
        normal_sequence();

        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
